// ----- hdl/hce_pkg.sv -----
// Shared types, constants and microcode table for the Hill cipher encryptor.
package hce_pkg;

  localparam int LETTER_W    = 5;
  localparam int KEY_ENTRY_W = 5;
  localparam int KEY_ROWS    = 4;
  localparam int KEY_COLS    = 4;
  localparam int KEY_ROW_W   = KEY_COLS * KEY_ENTRY_W;
  localparam int ROW_W       = $clog2(KEY_ROWS);
  localparam int BSIZE_W     = 3;
  localparam int FILL_W      = 3;
  localparam int DIM_W       = 3;
  localparam int PROD_W      = 2 * LETTER_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = KEY_ROW_W;
  localparam int MAX_DIM_DEF = 4;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = 3'd2;

  // mod 26 by reciprocal: q = (x * RECIP) >> RECIP_SH is exact for x < 4096
  localparam int MODULUS  = 26;
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((1 << RECIP_SH) + MODULUS - 1) / MODULUS;
  localparam int RECIP_W  = RECIP_SH - 3;
  localparam int QUOT_W   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_THREE = 3'd4;

  typedef logic [1:0] step_t;
  localparam step_t STEP_FETCH = 2'd0;
  localparam step_t STEP_MAC   = 2'd1;
  localparam step_t STEP_EMIT  = 2'd2;

  typedef enum logic [1:0] {
    OP_FETCH,
    OP_MAC,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_BLOCK_FULL,
    COND_COL_LAST,
    COND_ROW_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump_to;
    step_t next_to;
  } uop_t;

  typedef struct packed {
    logic take_letter;
    logic mac;
    logic emit;
  } hce_ctrl_t;

  typedef struct packed {
    logic block_full;
    logic col_last;
    logic row_last;
    logic out_free;
  } hce_stat_t;

  function automatic uop_t ucode_rom(input step_t step);
    uop_t w;
    case (step)
      STEP_FETCH: w = '{op: OP_FETCH, cond: COND_BLOCK_FULL,
                        jump_to: STEP_MAC, next_to: STEP_FETCH};
      STEP_MAC:   w = '{op: OP_MAC, cond: COND_COL_LAST,
                        jump_to: STEP_EMIT, next_to: STEP_MAC};
      STEP_EMIT:  w = '{op: OP_EMIT, cond: COND_ROW_LAST,
                        jump_to: STEP_FETCH, next_to: STEP_MAC};
      default:    w = '{op: OP_FETCH, cond: COND_BLOCK_FULL,
                        jump_to: STEP_FETCH, next_to: STEP_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [LETTER_W-1:0] mod26(input logic [ACC_W-1:0] x);
    logic [ACC_W+RECIP_W-1:0] p;
    logic [QUOT_W-1:0]        q;
    logic [ACC_W:0]           q26;
    logic [ACC_W-1:0]         r;
    p   = x * RECIP_W'(RECIP);
    q   = QUOT_W'(p >> RECIP_SH);
    q26 = ((ACC_W+1)'(q) << 4) + ((ACC_W+1)'(q) << 3) + ((ACC_W+1)'(q) << 1);
    r   = ACC_W'(x - q26[ACC_W-1:0]);
    if (r >= ACC_W'(MODULUS)) begin
      r = r - ACC_W'(MODULUS);
    end
    return r[LETTER_W-1:0];
  endfunction

endpackage

// ----- hdl/hce_in_if.sv -----
// Plaintext letter request channel.
interface hce_in_if;
  import hce_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] plain_letter;
  modport source (output valid, output plain_letter, input ready);
  modport sink (input valid, input plain_letter, output ready);
endinterface

// ----- hdl/hce_out_if.sv -----
// Cipher letter result channel.
interface hce_out_if;
  import hce_pkg::*;
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_letter;
  logic                block_last;
  modport source (output valid, output cipher_letter, output block_last, input ready);
  modport sink (input valid, input cipher_letter, input block_last, output ready);
endinterface

// ----- hdl/hce_cfg_if.sv -----
// Register write channel.
interface hce_cfg_if;
  import hce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/hce_cfg_regs.sv -----
// Block size and key matrix registers.
module hce_cfg_regs (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_valid,
  input  logic [hce_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [hce_pkg::CFG_DATA_W-1:0]               cfg_data,
  output logic                                         cfg_ready,
  output logic [hce_pkg::BSIZE_W-1:0]                  block_size,
  output logic [hce_pkg::KEY_ROWS-1:0][hce_pkg::KEY_ROW_W-1:0] key_rows
);
  import hce_pkg::*;

  logic [BSIZE_W-1:0]                  block_size_r;
  logic [KEY_ROWS-1:0][KEY_ROW_W-1:0]  key_rows_r;

  assign cfg_ready  = 1'b1;
  assign block_size = block_size_r;
  assign key_rows   = key_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BSIZE_RST;
      key_rows_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:    block_size_r  <= cfg_data[BSIZE_W-1:0];
        CFG_KEY_ROW_ZERO:  key_rows_r[0] <= cfg_data[KEY_ROW_W-1:0];
        CFG_KEY_ROW_ONE:   key_rows_r[1] <= cfg_data[KEY_ROW_W-1:0];
        CFG_KEY_ROW_TWO:   key_rows_r[2] <= cfg_data[KEY_ROW_W-1:0];
        CFG_KEY_ROW_THREE: key_rows_r[3] <= cfg_data[KEY_ROW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/hce_sequencer.sv -----
// Microcode step counter: fetches control words and resolves jumps.
module hce_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  hce_pkg::hce_stat_t stat,
  output logic               in_ready,
  output hce_pkg::hce_ctrl_t ctrl
);
  import hce_pkg::*;

  step_t step_r;
  step_t step_nxt;
  uop_t  uop;
  logic  stall;
  logic  take;

  assign uop = ucode_rom(step_r);

  // next step
  always_comb begin
    case (uop.op)
      OP_FETCH: stall = !in_valid;
      OP_MAC:   stall = 1'b0;
      OP_EMIT:  stall = !stat.out_free;
      default:  stall = 1'b1;
    endcase
    case (uop.cond)
      COND_BLOCK_FULL: take = stat.block_full;
      COND_COL_LAST:   take = stat.col_last;
      COND_ROW_LAST:   take = stat.row_last;
      default:         take = 1'b0;
    endcase
    if (stall) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = uop.jump_to;
    end else begin
      step_nxt = uop.next_to;
    end
  end

  // control outputs
  always_comb begin
    in_ready         = (uop.op == OP_FETCH);
    ctrl.take_letter = (uop.op == OP_FETCH) && in_valid;
    ctrl.mac         = (uop.op == OP_MAC);
    ctrl.emit        = (uop.op == OP_EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_EMIT && !stat.out_free) |=> step_r == STEP_EMIT)
    else $error("emit step left while output register busy");
  a_step_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_FETCH || step_r == STEP_MAC || step_r == STEP_EMIT))
    else $error("step counter outside the program");
  a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_FETCH && !in_valid) |=> step_r == STEP_FETCH)
    else $error("fetch step left without a request");
`endif

endmodule

// ----- hdl/hce_datapath.sv -----
// Letter buffer, single multiply-accumulate, mod 26 reduction, output register.
module hce_datapath #(
  parameter int MAX_DIM = hce_pkg::MAX_DIM_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  hce_pkg::hce_ctrl_t                           ctrl,
  input  logic [hce_pkg::LETTER_W-1:0]                 plain_letter,
  input  logic [hce_pkg::BSIZE_W-1:0]                  block_size,
  input  logic [hce_pkg::KEY_ROWS-1:0][hce_pkg::KEY_ROW_W-1:0] key_rows,
  input  logic                                         out_ready,
  output logic                                         out_valid,
  output logic [hce_pkg::LETTER_W-1:0]                 cipher_letter,
  output logic                                         block_last,
  output hce_pkg::hce_stat_t                           stat
);
  import hce_pkg::*;

  localparam int CAP   = (MAX_DIM < KEY_ROWS) ? MAX_DIM : KEY_ROWS;
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [LETTER_W-1:0] buf_r [MAX_DIM];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ROW_W-1:0]    col_r, col_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] out_letter_r;
  logic                out_last_r;

  logic [DIM_W-1:0]       dim;
  logic [KEY_ENTRY_W-1:0] key_ent;
  logic [LETTER_W-1:0]    buf_rd;
  logic [PROD_W-1:0]      prod;

  // zero acts as one, anything above the cap acts as the cap
  always_comb begin
    if (block_size == '0) begin
      dim = DIM_W'(1);
    end else if (DIM_W'(block_size) > DIM_W'(CAP)) begin
      dim = DIM_W'(CAP);
    end else begin
      dim = DIM_W'(block_size);
    end
  end

  assign key_ent = key_rows[row_r][col_r*KEY_ENTRY_W +: KEY_ENTRY_W];
  assign buf_rd  = buf_r[IDX_W'(col_r)];
  assign prod    = key_ent * buf_rd;

  assign stat.block_full = (FILL_W'(fill_r + FILL_W'(1)) >= FILL_W'(dim));
  assign stat.col_last   = (DIM_W'(col_r) + DIM_W'(1) == dim);
  assign stat.row_last   = (DIM_W'(row_r) + DIM_W'(1) == dim);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    fill_nxt      = fill_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (ctrl.take_letter) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (ctrl.mac) begin
      acc_nxt = acc_r + ACC_W'(prod);
      col_nxt = col_r + ROW_W'(1);
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      acc_nxt       = '0;
      col_nxt       = '0;
      if (stat.row_last) begin
        row_nxt  = '0;
        fill_nxt = '0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_letter && (int'(fill_r) < MAX_DIM)) begin
      buf_r[IDX_W'(fill_r)] <= plain_letter;
    end
    if (ctrl.emit) begin
      out_letter_r <= mod26(acc_r);
      out_last_r   <= stat.row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign cipher_letter = out_letter_r;
  assign block_last    = out_last_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take_letter |-> (int'(fill_r) < CAP))
    else $error("letter taken with buffer already full");
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && stat.row_last) |=> (fill_r == '0 && row_r == '0 && col_r == '0))
    else $error("counters not cleared after last row");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while held");
`endif

endmodule

// ----- hdl/hill_cipher_encrypt.sv -----
// Hill cipher encryptor, mod 26. Letters 0..25 enter one per request and are buffered until
// block_size (1..4) of them are held; the block is then multiplied by the key matrix on one
// shared multiply-accumulate run by a three-word microcode program, and block_size cipher
// letters leave in row order, the last flagged by block_last. Each letter is taken in the
// fetch step; a block of n letters is then worked row by row, n MAC steps plus one reduce
// and emit step per row, and the emit step waits while the output register is still held.
// Input is not taken while a block is being computed. No clearing pass follows reset.
module hill_cipher_encrypt #(
  parameter int MAX_DIM = hce_pkg::MAX_DIM_DEF
) (
  input logic      clk,
  input logic      rst_n,
  hce_cfg_if.sink  cfg_ch,
  hce_in_if.sink   in_ch,
  hce_out_if.source out_ch
);
  import hce_pkg::*;

  hce_ctrl_t                          ctrl;
  hce_stat_t                          stat;
  logic [BSIZE_W-1:0]                 block_size;
  logic [KEY_ROWS-1:0][KEY_ROW_W-1:0] key_rows;

  hce_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .cfg_ready  (cfg_ch.ready),
    .block_size (block_size),
    .key_rows   (key_rows)
  );

  hce_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl)
  );

  hce_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .plain_letter  (in_ch.plain_letter),
    .block_size    (block_size),
    .key_rows      (key_rows),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .cipher_letter (out_ch.cipher_letter),
    .block_last    (out_ch.block_last),
    .stat          (stat)
  );

endmodule

// ----- tb/sv/hce_checker.sv -----
// Scoreboard for the Hill cipher encryptor: predicts each block's cipher letters and checks them.
module hce_checker #(
  parameter int MAX_DIM = hce_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hce_cfg_if          cfg_ch,
  hce_in_if           in_ch,
  hce_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hce_pkg::*;

  localparam int DIM_CAP      = (MAX_DIM < KEY_ROWS) ? MAX_DIM : KEY_ROWS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                block_last;
  } cipher_t;

  logic [BSIZE_W-1:0]   block_size;
  logic [KEY_ROW_W-1:0] key_row [KEY_ROWS];
  logic [LETTER_W-1:0]  held_letter [MAX_DIM];
  logic [FILL_W-1:0]    held_count;
  cipher_t              cipher_queue [$];

  // Buffer one plaintext letter; a full block queues one cipher letter for each of its dim key rows.
  task automatic encrypt_letter(input logic [LETTER_W-1:0] letter);
    int unsigned dim;
    int unsigned acc;
    cipher_t     ct;
    dim = (block_size == 0) ? 1 : ((block_size > DIM_CAP) ? DIM_CAP : block_size);
    if (held_count < MAX_DIM) begin
      held_letter[held_count] = letter;
    end
    held_count = held_count + 1'b1;
    // count kept across a size change, so it may already be past the new size
    if (held_count >= dim) begin
      for (int r = 0; r < dim; r++) begin
        acc = 0;
        for (int c = 0; c < dim; c++) begin
          acc += key_row[r][c*KEY_ENTRY_W +: KEY_ENTRY_W] * held_letter[c];
        end
        ct.cipher_letter = LETTER_W'(acc % MODULUS);
        ct.block_last    = (r == dim - 1);
        cipher_queue     = {cipher_queue, ct};
      end
      held_count = '0;
    end
  endtask

  always @(posedge clk) begin
    cipher_t got;
    cipher_t want;
    if (!rst_n) begin
      fail_count = 0;
      block_size = BSIZE_RST;
      foreach (key_row[i]) key_row[i] = '0;
      held_count = '0;
      cipher_queue.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cipher_letter, out_ch.block_last};
        if (cipher_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result: cipher %0d last %0b",
                     got.cipher_letter, got.block_last);
          end
        end else begin
          want = cipher_queue.pop_front();
          if (got.cipher_letter !== want.cipher_letter ||
              got.block_last !== want.block_last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("mismatch: expected cipher %0d last %0b, got cipher %0d last %0b",
                       want.cipher_letter, want.block_last,
                       got.cipher_letter, got.block_last);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BLOCK_SIZE: block_size = cfg_ch.data[BSIZE_W-1:0];
          CFG_KEY_ROW_ZERO, CFG_KEY_ROW_ONE, CFG_KEY_ROW_TWO, CFG_KEY_ROW_THREE: begin
            key_row[cfg_ch.index - CFG_KEY_ROW_ZERO] = cfg_ch.data[KEY_ROW_W-1:0];
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        encrypt_letter(in_ch.plain_letter);
      end
    end
    pending = cipher_queue.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the Hill cipher encryptor testbench: clock, reset, requests, stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hce_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 52;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {KEY_LETTERS, KEY_RAW, KEY_ZERO, KEY_ONES} key_kind_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count;
  int unsigned pending;

  hce_cfg_if cfg_ch ();
  hce_in_if  in_ch ();
  hce_out_if out_ch ();

  hill_cipher_encrypt dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hce_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [KEY_ROW_W-1:0] make_key_row(input key_kind_t kind);
    logic [KEY_ROW_W-1:0] row;
    row = '0;
    case (kind)
      KEY_LETTERS: begin
        for (int c = 0; c < KEY_COLS; c++) begin
          row[c*KEY_ENTRY_W +: KEY_ENTRY_W] = KEY_ENTRY_W'($urandom_range(MODULUS - 1));
        end
      end
      KEY_RAW:  row = KEY_ROW_W'($urandom);
      KEY_ONES: row = '1;
      default:  row = '0;
    endcase
    return row;
  endfunction

  // mostly real letters, some raw 5-bit codes past Z
  function automatic logic [LETTER_W-1:0] random_letter();
    if ($urandom_range(99) < 15) begin
      return LETTER_W'($urandom_range(2**LETTER_W - 1, MODULUS));
    end
    return LETTER_W'($urandom_range(MODULUS - 1));
  endfunction

  function automatic logic [CFG_IDX_W-1:0] unused_index();
    return CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_KEY_ROW_THREE + 1));
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    gap_pct   = (mode == IDLE_SENDER) ? 72 : (mode == IDLE_BOTH) ? 17 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 72 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // upper data bits are junk on purpose; only the low bits are the size
  task automatic set_block_size(input logic [BSIZE_W-1:0] bsize);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom);
    value[BSIZE_W-1:0] = bsize;
    cfg_write(CFG_BLOCK_SIZE, value);
  endtask

  task automatic load_keys(input key_kind_t kind);
    for (int r = 0; r < KEY_ROWS; r++) begin
      cfg_write(CFG_IDX_W'(CFG_KEY_ROW_ZERO + r), make_key_row(kind));
    end
  endtask

  // valid is left high after the request so back-to-back letters need no gap
  task automatic send_letter(input logic [LETTER_W-1:0] letter);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.plain_letter = letter;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_letter(random_letter());
  endtask

  // hold off until every cipher letter is out and the block has gone quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    key_kind_t kind;
    in_ch.valid        = 1'b0;
    in_ch.plain_letter = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_BLOCK_SIZE;
    cfg_ch.data        = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: size 2, all-zero key
    send_letter('0);
    send_letter(LETTER_W'(MODULUS - 1));
    settle();

    // largest size, largest key entries and letters
    set_block_size(BSIZE_W'(4));
    load_keys(KEY_ONES);
    cfg_write(unused_index(), '1);
    repeat (4) send_letter('1);
    settle();

    set_block_size(BSIZE_W'(1));
    cfg_write(CFG_KEY_ROW_ZERO, CFG_DATA_W'(MODULUS - 1));
    send_letter(LETTER_W'(MODULUS));
    send_letter('0);
    settle();

    // size zero behaves as one, size seven as four
    set_block_size('0);
    send_random(1);
    settle();
    set_block_size('1);
    load_keys(KEY_LETTERS);
    send_random(4);
    settle();

    // shrink the size with letters already buffered
    set_block_size(BSIZE_W'(3));
    send_random(2);
    settle();
    set_block_size(BSIZE_W'(2));
    send_random(1);
    settle();
    set_block_size(BSIZE_W'(4));
    send_random(3);
    settle();
    set_block_size(BSIZE_W'(3));
    send_random(1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_idle(idle_mode_t'(p % 4));
      case (p)
        0: begin
          set_block_size(BSIZE_W'(1));
          load_keys(KEY_LETTERS);
        end
        1: begin
          set_block_size(BSIZE_W'(4));
          load_keys(KEY_ONES);
        end
        2: begin
          set_block_size(BSIZE_W'(4));
          load_keys(KEY_ZERO);
        end
        default: begin
          set_block_size(($urandom_range(99) < 15) ? BSIZE_W'($urandom)
                                                   : BSIZE_W'($urandom_range(4, 1)));
          kind = ($urandom_range(3) == 0) ? KEY_RAW : KEY_LETTERS;
          load_keys(kind);
        end
      endcase
      if ($urandom_range(1) == 1) begin
        cfg_write(unused_index(), CFG_DATA_W'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p >= 4 && i == PHASE_ITEMS / 2) begin
          settle();
          set_block_size(BSIZE_W'($urandom_range(4, 1)));
        end
        send_letter(random_letter());
      end
      settle();
    end

    // trailing partial block gives nothing
    set_idle(IDLE_NONE);
    set_block_size(BSIZE_W'(4));
    send_random(2);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
